// ===== src/fp32ta_pkg.sv =====
// Package with the field widths and helper functions of the truncating adder.
`timescale 1ns / 1ps

package fp32ta_pkg;

   localparam int FRAC_W    = 23;            // stored fraction bits
   localparam int EXP_W     = 8;             // exponent field bits
   localparam int MAN_W     = FRAC_W + 1;    // mantissa with hidden bit
   localparam int SUM_W     = MAN_W + 1;     // mantissa sum with carry
   localparam int PEXP_W    = EXP_W + 1;     // exponent bits that reach the packed word
   localparam int LZ_W      = 5;             // leading-zero count over the sum
   localparam int DIFF_W    = 5;             // capped alignment distance
   localparam int ALIGN_CAP = 24;

   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [EXP_W-1:0]  exp_type;
   typedef logic [MAN_W-1:0]  man_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [LZ_W-1:0]   lz_type;
   typedef logic [DIFF_W-1:0] diff_type;

   // Leading zeros of the mantissa sum; an all-zero sum gives SUM_W.
   function automatic lz_type count_lz(input sum_type value);
      lz_type n;
      logic   found;
      n     = LZ_W'(SUM_W);
      found = 1'b0;
      for (int i = SUM_W - 1; i >= 0; i--) begin
         if (value[i] && !found) begin
            n     = LZ_W'(SUM_W - 1 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

// ===== src/fp32_truncating_adder.sv =====
// Four-stage pipelined single-precision adder with truncation and no special cases.
`timescale 1ns / 1ps

// fp32_truncating_adder adds two single-precision bit patterns and returns the
// sum as a bit pattern. It accepts one transfer per cycle while the result
// side does not stall, and each result passes through four register stages
// (order and align distance, mantissa add, leading-zero count, normalize and
// pack). A stall on the result side freezes the whole pipeline, so nothing
// is lost or repeated. There is no rounding and no handling of zero,
// denormal, infinity or NaN: the hidden bit is always set, dropped bits are
// truncated, and the exponent wraps into the sign bit on overflow or
// underflow. An exact cancellation returns the lead sign with the exponent
// lowered by 24.
module fp32_truncating_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sum_bits
);

   logic advance;

   // Stage 1: ordered operands.
   logic                 s1_valid_ff;
   logic                 s1_sign_ff, s1_sub_ff;
   fp32ta_pkg::exp_type  s1_exp_ff;
   fp32ta_pkg::frac_type s1_big_frac_ff, s1_small_frac_ff;
   fp32ta_pkg::diff_type s1_diff_ff;

   // Stage 2: mantissa sum.
   logic                 s2_valid_ff, s2_sign_ff;
   fp32ta_pkg::exp_type  s2_exp_ff;
   fp32ta_pkg::sum_type  s2_sum_ff;

   // Stage 3: leading-zero count.
   logic                 s3_valid_ff, s3_sign_ff;
   fp32ta_pkg::exp_type  s3_exp_ff;
   fp32ta_pkg::sum_type  s3_sum_ff;
   fp32ta_pkg::lz_type   s3_lz_ff;

   // Stage 4: packed result.
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_sum_ff;

   // The whole pipeline moves unless a finished result is being held.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage 1 logic: the operand with the larger magnitude leads; equal
   // magnitudes keep operand_a in the lead.
   logic [31:0]          big_in, small_in;
   logic [fp32ta_pkg::EXP_W-1:0] exp_diff_in;
   fp32ta_pkg::diff_type diff_in;

   always_comb begin
      if (req_operand_a[30:0] < req_operand_b[30:0]) begin
         big_in   = req_operand_b;
         small_in = req_operand_a;
      end else begin
         big_in   = req_operand_a;
         small_in = req_operand_b;
      end
      exp_diff_in = big_in[30:23] - small_in[30:23];
      if (exp_diff_in > fp32ta_pkg::EXP_W'(fp32ta_pkg::ALIGN_CAP)) begin
         diff_in = fp32ta_pkg::DIFF_W'(fp32ta_pkg::ALIGN_CAP);
      end else begin
         diff_in = exp_diff_in[fp32ta_pkg::DIFF_W-1:0];
      end
   end

   // Stage 2 logic: align the smaller mantissa and add or subtract. The lead
   // mantissa is never below the aligned one, so the result is not negative.
   fp32ta_pkg::man_type big_man, small_man;
   fp32ta_pkg::sum_type sum_in;

   always_comb begin
      big_man   = {1'b1, s1_big_frac_ff};
      small_man = {1'b1, s1_small_frac_ff} >> s1_diff_ff;
      if (s1_sub_ff) begin
         sum_in = {1'b0, big_man} - {1'b0, small_man};
      end else begin
         sum_in = {1'b0, big_man} + {1'b0, small_man};
      end
   end

   // Stage 4 logic: a shift left by the count, taken from a word with one
   // extra low bit, covers both the carry case (one step right) and the
   // cancellation cases (steps left).
   logic [fp32ta_pkg::SUM_W:0]    norm_word;
   logic [fp32ta_pkg::PEXP_W-1:0] exp_out;

   always_comb begin
      norm_word = {s3_sum_ff, 1'b0} << s3_lz_ff;
      exp_out   = {1'b0, s3_exp_ff} + fp32ta_pkg::PEXP_W'(1)
                  - fp32ta_pkg::PEXP_W'(s3_lz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sign_ff       <= big_in[31];
         s1_sub_ff        <= big_in[31] ^ small_in[31];
         s1_exp_ff        <= big_in[30:23];
         s1_big_frac_ff   <= big_in[22:0];
         s1_small_frac_ff <= small_in[22:0];
         s1_diff_ff       <= diff_in;

         s2_sign_ff <= s1_sign_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_sum_ff  <= sum_in;

         s3_sign_ff <= s2_sign_ff;
         s3_exp_ff  <= s2_exp_ff;
         s3_sum_ff  <= s2_sum_ff;
         s3_lz_ff   <= fp32ta_pkg::count_lz(s2_sum_ff);

         // Exponent bit 8 lands on bit 31 and is OR-ed with the sign.
         rsp_sum_ff <= {s3_sign_ff | exp_out[8], exp_out[7:0],
                        norm_word[fp32ta_pkg::SUM_W-1:2]};
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sum_bits = rsp_sum_ff;

endmodule
